FILE: src/hrp_pkg.sv
// Shared types, codes and token tables for the HTTP request header parser.
// No dependencies; used by every other file of the block.
package hrp_pkg;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_URL     = 3'd1,
    PH_VERSION = 3'd2,
    PH_HEADER  = 3'd3,
    PH_BLANK   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    DIG_SKIP = 2'd0,
    DIG_READ = 2'd1,
    DIG_STOP = 2'd2
  } dig_t;

  // result status codes
  localparam logic [1:0] ST_DONE        = 2'd0;
  localparam logic [1:0] ST_BAD_METHOD  = 2'd1;
  localparam logic [1:0] ST_TRUNCATED   = 2'd2;

  // method codes
  localparam logic [1:0] METHOD_NONE = 2'd0;
  localparam logic [1:0] METHOD_GET  = 2'd1;
  localparam logic [1:0] METHOD_POST = 2'd2;

  // characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // token lengths, compared against the 4-bit match position
  localparam logic [3:0] GET_LEN     = 4'd3;
  localparam logic [3:0] POST_LEN    = 4'd4;
  localparam logic [3:0] VERSION_LEN = 4'd9;
  localparam logic [3:0] LENGTH_LEN  = 4'd14;
  localparam logic [3:0] ALIVE_LEN   = 4'd10;
  localparam logic [3:0] POS_MAX     = 4'd15;

  // magnitude limit of the value parser (2^31)
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         method_code;
    logic [15:0]        url_offset;
    logic [15:0]        url_length;
    logic               version_ok;
    logic signed [31:0] body_length;
    logic               length_seen;
    logic               persistent;
    logic [15:0]        body_offset;
  } result_t;

  function automatic logic get_hit(logic [3:0] pos, logic [7:0] b);
    logic [7:0] ch;
    logic       ok;
    ch = 8'h00;
    ok = 1'b1;
    case (pos)
      4'd0: ch = "G";
      4'd1: ch = "E";
      4'd2: ch = "T";
      default: ok = 1'b0;
    endcase
    return ok && (ch == b);
  endfunction

  function automatic logic post_hit(logic [3:0] pos, logic [7:0] b);
    logic [7:0] ch;
    logic       ok;
    ch = 8'h00;
    ok = 1'b1;
    case (pos)
      4'd0: ch = "P";
      4'd1: ch = "O";
      4'd2: ch = "S";
      4'd3: ch = "T";
      default: ok = 1'b0;
    endcase
    return ok && (ch == b);
  endfunction

  function automatic logic version_hit(logic [3:0] pos, logic [7:0] b);
    logic [7:0] ch;
    logic       ok;
    ch = 8'h00;
    ok = 1'b1;
    case (pos)
      4'd0: ch = "H";
      4'd1: ch = "T";
      4'd2: ch = "T";
      4'd3: ch = "P";
      4'd4: ch = "/";
      4'd5: ch = "1";
      4'd6: ch = ".";
      4'd7: ch = "1";
      4'd8: ch = CH_CR;
      default: ok = 1'b0;
    endcase
    return ok && (ch == b);
  endfunction

  function automatic logic length_hit(logic [3:0] pos, logic [7:0] b);
    logic [7:0] ch;
    logic       ok;
    ch = 8'h00;
    ok = 1'b1;
    case (pos)
      4'd0:  ch = "C";
      4'd1:  ch = "o";
      4'd2:  ch = "n";
      4'd3:  ch = "t";
      4'd4:  ch = "e";
      4'd5:  ch = "n";
      4'd6:  ch = "t";
      4'd7:  ch = "-";
      4'd8:  ch = "L";
      4'd9:  ch = "e";
      4'd10: ch = "n";
      4'd11: ch = "g";
      4'd12: ch = "t";
      4'd13: ch = "h";
      default: ok = 1'b0;
    endcase
    return ok && (ch == b);
  endfunction

  function automatic logic alive_hit(logic [3:0] pos, logic [7:0] b);
    logic [7:0] ch;
    logic       ok;
    ch = 8'h00;
    ok = 1'b1;
    case (pos)
      4'd0: ch = "k";
      4'd1: ch = "e";
      4'd2: ch = "e";
      4'd3: ch = "p";
      4'd4: ch = "-";
      4'd5: ch = "a";
      4'd6: ch = "l";
      4'd7: ch = "i";
      4'd8: ch = "v";
      4'd9: ch = "e";
      default: ok = 1'b0;
    endcase
    return ok && (ch == b);
  endfunction

endpackage

FILE: src/hrp_parse.sv
// Parse state and per-byte update of the HTTP request header parser.
// Depends on hrp_pkg (item and result types, token tables, codes).
module hrp_parse #(
  parameter int OFFSET_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  hrp_pkg::item_t  item,
  output logic            res_valid,  // this byte finishes a summary
  output hrp_pkg::result_t res
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

  function automatic logic [OFFSET_BITS-1:0] off_inc(logic [OFFSET_BITS-1:0] v);
    return (v == OFF_MAX) ? v : v + OFF_ONE;
  endfunction

  function automatic logic [15:0] sat16(logic [OFFSET_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [3:0] pos_inc(logic [3:0] p);
    return (p == hrp_pkg::POS_MAX) ? p : p + 4'd1;
  endfunction

  // state registers
  hrp_pkg::phase_t        phase;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [3:0]             match_position;
  logic [1:0]             match_candidates;  // [0] length/GET, [1] alive/POST
  logic [OFFSET_BITS-1:0] url_start;
  logic [OFFSET_BITS-1:0] url_count;
  logic [1:0]             method_seen;
  logic                   version_match;
  logic                   line_start;
  logic                   in_value;
  logic [31:0]            value_accumulator;
  logic                   value_negative;
  hrp_pkg::dig_t          digits_state;
  logic                   pending_valid;
  logic [7:0]             pending_byte;
  logic                   length_found;
  logic                   alive_found;
  logic                   done_flag;

  // state as seen by this byte: a first byte starts from reset values
  hrp_pkg::phase_t        c_phase;
  logic [OFFSET_BITS-1:0] c_off;
  logic [3:0]             c_pos;
  logic [1:0]             c_cands;
  logic [OFFSET_BITS-1:0] c_url_start;
  logic [OFFSET_BITS-1:0] c_url_count;
  logic [1:0]             c_method;
  logic                   c_vmatch;
  logic                   c_line_start;
  logic                   c_in_value;
  logic [31:0]            c_acc;
  logic                   c_neg;
  hrp_pkg::dig_t          c_dig;
  logic                   c_pend_v;
  logic [7:0]             c_pend_b;
  logic                   c_len_found;
  logic                   c_alive;
  logic                   c_done;

  logic first;
  assign first = item.first_byte;

  assign c_phase      = first ? hrp_pkg::PH_METHOD : phase;
  assign c_off        = first ? '0 : byte_offset;
  assign c_pos        = first ? 4'd0 : match_position;
  assign c_cands      = first ? 2'b11 : match_candidates;
  assign c_url_start  = first ? '0 : url_start;
  assign c_url_count  = first ? '0 : url_count;
  assign c_method     = first ? hrp_pkg::METHOD_NONE : method_seen;
  assign c_vmatch     = first ? 1'b1 : version_match;
  assign c_line_start = first ? 1'b0 : line_start;
  assign c_in_value   = first ? 1'b0 : in_value;
  assign c_acc        = first ? 32'd0 : value_accumulator;
  assign c_neg        = first ? 1'b0 : value_negative;
  assign c_dig        = first ? hrp_pkg::DIG_SKIP : digits_state;
  assign c_pend_v     = first ? 1'b0 : pending_valid;
  assign c_pend_b     = pending_byte;
  assign c_len_found  = first ? 1'b0 : length_found;
  assign c_alive      = first ? 1'b0 : alive_found;
  assign c_done       = first ? 1'b0 : done_flag;

  // value digit step: acc * 10 + digit, saturated at 2^31
  logic [3:0]  dval;
  logic [35:0] acc_x10;
  logic [31:0] acc_step;
  logic        pend_digit;
  logic        pend_space;

  assign dval       = 4'(c_pend_b - hrp_pkg::CH_ZERO);
  assign acc_x10    = ({4'b0, c_acc} << 3) + ({4'b0, c_acc} << 1) + 36'(dval);
  assign acc_step   = (acc_x10 > 36'(hrp_pkg::MAG_LIMIT)) ? hrp_pkg::MAG_LIMIT : acc_x10[31:0];
  assign pend_digit = (c_pend_b >= hrp_pkg::CH_ZERO) && (c_pend_b <= hrp_pkg::CH_NINE);
  assign pend_space = (c_pend_b == hrp_pkg::CH_SP) || (c_pend_b == hrp_pkg::CH_TAB) ||
                      (c_pend_b == hrp_pkg::CH_VT) || (c_pend_b == hrp_pkg::CH_FF) ||
                      (c_pend_b == hrp_pkg::CH_CR);

  // next state
  hrp_pkg::phase_t        phase_next;
  logic [OFFSET_BITS-1:0] byte_offset_next;
  logic [3:0]             match_position_next;
  logic [1:0]             match_candidates_next;
  logic [OFFSET_BITS-1:0] url_start_next;
  logic [OFFSET_BITS-1:0] url_count_next;
  logic [1:0]             method_seen_next;
  logic                   version_match_next;
  logic                   line_start_next;
  logic                   in_value_next;
  logic [31:0]            value_accumulator_next;
  logic                   value_negative_next;
  hrp_pkg::dig_t          digits_state_next;
  logic                   pending_valid_next;
  logic [7:0]             pending_byte_next;
  logic                   length_found_next;
  logic                   alive_found_next;
  logic                   done_flag_next;

  logic       emit;
  logic [1:0] emit_status;
  logic       ok_get;
  logic       ok_post;
  logic       ok_end;
  logic [7:0] b;

  assign b = item.data_byte;

  always_comb begin
    phase_next             = c_phase;
    byte_offset_next       = c_off;
    match_position_next    = c_pos;
    match_candidates_next  = c_cands;
    url_start_next         = c_url_start;
    url_count_next         = c_url_count;
    method_seen_next       = c_method;
    version_match_next     = c_vmatch;
    line_start_next        = c_line_start;
    in_value_next          = c_in_value;
    value_accumulator_next = c_acc;
    value_negative_next    = c_neg;
    digits_state_next      = c_dig;
    pending_valid_next     = c_pend_v;
    pending_byte_next      = c_pend_b;
    length_found_next      = c_len_found;
    alive_found_next       = c_alive;
    done_flag_next         = c_done;
    emit                   = 1'b0;
    emit_status            = hrp_pkg::ST_DONE;
    ok_get                 = c_cands[0] && (c_pos == hrp_pkg::GET_LEN);
    ok_post                = c_cands[1] && (c_pos == hrp_pkg::POST_LEN);
    ok_end                 = 1'b0;

    if (!c_done) begin
      case (c_phase)
        hrp_pkg::PH_METHOD: begin
          if (b == hrp_pkg::CH_SP) begin
            if (ok_get) begin
              method_seen_next = hrp_pkg::METHOD_GET;
            end else if (ok_post) begin
              method_seen_next = hrp_pkg::METHOD_POST;
            end
            if (!ok_get && !ok_post) begin
              emit        = 1'b1;
              emit_status = hrp_pkg::ST_BAD_METHOD;
            end else begin
              phase_next     = hrp_pkg::PH_URL;
              url_start_next = off_inc(c_off);
              url_count_next = '0;
            end
          end else begin
            match_candidates_next = {c_cands[1] && hrp_pkg::post_hit(c_pos, b),
                                     c_cands[0] && hrp_pkg::get_hit(c_pos, b)};
            match_position_next   = pos_inc(c_pos);
          end
        end
        hrp_pkg::PH_URL: begin
          if (b == hrp_pkg::CH_SP) begin
            phase_next          = hrp_pkg::PH_VERSION;
            match_position_next = 4'd0;
            version_match_next  = 1'b1;
          end else begin
            url_count_next = off_inc(c_url_count);
          end
        end
        hrp_pkg::PH_VERSION: begin
          if (b == hrp_pkg::CH_LF) begin
            version_match_next    = c_vmatch && (c_pos == hrp_pkg::VERSION_LEN);
            phase_next            = hrp_pkg::PH_HEADER;
            match_position_next   = 4'd0;
            match_candidates_next = 2'b11;
            line_start_next       = 1'b1;
            in_value_next         = 1'b0;
            pending_valid_next    = 1'b0;
          end else begin
            version_match_next  = c_vmatch && hrp_pkg::version_hit(c_pos, b);
            match_position_next = pos_inc(c_pos);
          end
        end
        hrp_pkg::PH_HEADER: begin
          if (c_in_value) begin
            if (b == hrp_pkg::CH_LF) begin
              match_position_next   = 4'd0;
              match_candidates_next = 2'b11;
              line_start_next       = 1'b1;
              in_value_next         = 1'b0;
              pending_valid_next    = 1'b0;
            end else begin
              // the byte held back is fed now; the line's last byte never is
              if (c_pend_v && (c_dig != hrp_pkg::DIG_STOP)) begin
                if ((c_dig == hrp_pkg::DIG_SKIP) && pend_space) begin
                  digits_state_next = hrp_pkg::DIG_SKIP;
                end else if ((c_dig == hrp_pkg::DIG_SKIP) &&
                             ((c_pend_b == hrp_pkg::CH_PLUS) ||
                              (c_pend_b == hrp_pkg::CH_MINUS))) begin
                  value_negative_next = (c_pend_b == hrp_pkg::CH_MINUS);
                  digits_state_next   = hrp_pkg::DIG_READ;
                end else if (pend_digit) begin
                  digits_state_next      = hrp_pkg::DIG_READ;
                  value_accumulator_next = acc_step;
                end else begin
                  digits_state_next = hrp_pkg::DIG_STOP;
                end
              end
              pending_valid_next = 1'b1;
              pending_byte_next  = b;
            end
          end else if (c_line_start && (b == hrp_pkg::CH_CR)) begin
            phase_next = hrp_pkg::PH_BLANK;
          end else if (b == hrp_pkg::CH_LF) begin
            match_position_next   = 4'd0;
            match_candidates_next = 2'b11;
            line_start_next       = 1'b1;
            in_value_next         = 1'b0;
            pending_valid_next    = 1'b0;
          end else if ((b == hrp_pkg::CH_COLON) || (b == hrp_pkg::CH_SP)) begin
            if (c_cands[1] && (c_pos == hrp_pkg::ALIVE_LEN)) begin
              alive_found_next = 1'b1;
            end
            digits_state_next = hrp_pkg::DIG_STOP;
            if (c_cands[0] && (c_pos == hrp_pkg::LENGTH_LEN) && !c_len_found) begin
              length_found_next      = 1'b1;
              digits_state_next      = hrp_pkg::DIG_SKIP;
              value_accumulator_next = 32'd0;
              value_negative_next    = 1'b0;
            end
            in_value_next      = 1'b1;
            pending_valid_next = 1'b0;
            line_start_next    = 1'b0;
          end else begin
            match_candidates_next = {c_cands[1] && hrp_pkg::alive_hit(c_pos, b),
                                     c_cands[0] && hrp_pkg::length_hit(c_pos, b)};
            match_position_next   = pos_inc(c_pos);
            line_start_next       = 1'b0;
          end
        end
        hrp_pkg::PH_BLANK: begin
          if (b == hrp_pkg::CH_LF) begin
            emit        = 1'b1;
            emit_status = hrp_pkg::ST_DONE;
          end
        end
        default: begin
          phase_next = c_phase;
        end
      endcase

      if (!emit && item.last_byte) begin
        emit = 1'b1;
        if (phase_next == hrp_pkg::PH_METHOD) begin
          ok_end = (match_candidates_next[0] && (match_position_next == hrp_pkg::GET_LEN)) ||
                   (match_candidates_next[1] && (match_position_next == hrp_pkg::POST_LEN));
          emit_status = ok_end ? hrp_pkg::ST_TRUNCATED : hrp_pkg::ST_BAD_METHOD;
        end else begin
          emit_status = hrp_pkg::ST_TRUNCATED;
        end
      end

      if (emit) begin
        done_flag_next = 1'b1;
      end else begin
        byte_offset_next = off_inc(c_off);
      end
    end
  end

  // result fields from the updated state
  logic [31:0] body_mag;

  always_comb begin
    if (value_negative_next) begin
      body_mag = 32'd0 - value_accumulator_next;
    end else if (value_accumulator_next > hrp_pkg::POS_LIMIT) begin
      body_mag = hrp_pkg::POS_LIMIT;
    end else begin
      body_mag = value_accumulator_next;
    end

    res = '0;
    res.status = emit_status;
    if (emit_status != hrp_pkg::ST_BAD_METHOD) begin
      res.method_code = method_seen_next;
      res.url_offset  = sat16(url_start_next);
      res.url_length  = sat16(url_count_next);
      res.version_ok  = ((phase_next == hrp_pkg::PH_HEADER) ||
                         (phase_next == hrp_pkg::PH_BLANK)) && version_match_next;
      res.body_length = length_found_next ? body_mag : 32'sd0;
      res.length_seen = length_found_next;
      res.persistent  = alive_found_next;
      res.body_offset = (emit_status == hrp_pkg::ST_DONE) ? sat16(off_inc(c_off)) : 16'd0;
    end
  end

  // depends only on the input byte and the state, so the caller can gate fire on it
  assign res_valid = emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= hrp_pkg::PH_METHOD;
      byte_offset       <= '0;
      match_position    <= 4'd0;
      match_candidates  <= 2'b11;
      url_start         <= '0;
      url_count         <= '0;
      method_seen       <= hrp_pkg::METHOD_NONE;
      version_match     <= 1'b1;
      line_start        <= 1'b0;
      in_value          <= 1'b0;
      value_accumulator <= 32'd0;
      value_negative    <= 1'b0;
      digits_state      <= hrp_pkg::DIG_SKIP;
      pending_valid     <= 1'b0;
      length_found      <= 1'b0;
      alive_found       <= 1'b0;
      done_flag         <= 1'b0;
    end else if (fire) begin
      phase             <= phase_next;
      byte_offset       <= byte_offset_next;
      match_position    <= match_position_next;
      match_candidates  <= match_candidates_next;
      url_start         <= url_start_next;
      url_count         <= url_count_next;
      method_seen       <= method_seen_next;
      version_match     <= version_match_next;
      line_start        <= line_start_next;
      in_value          <= in_value_next;
      value_accumulator <= value_accumulator_next;
      value_negative    <= value_negative_next;
      digits_state      <= digits_state_next;
      pending_valid     <= pending_valid_next;
      length_found      <= length_found_next;
      alive_found       <= alive_found_next;
      done_flag         <= done_flag_next;
    end
  end

  // held byte is payload, qualified by pending_valid
  always_ff @(posedge clk) begin
    if (fire) begin
      pending_byte <= pending_byte_next;
    end
  end

endmodule

FILE: src/http_request_header_parser.sv
// HTTP request header parser, one request byte per transfer. The block takes
// the request text a byte at a time (first_byte opens a new request and clears
// all parse state) and gives one summary transfer when the blank line that
// ends the header arrives, when the method token is neither GET nor POST, or
// when last_byte closes the buffer. The summary carries the method, URL offset
// and length, the version check against "HTTP/1.1" CR, the first
// Content-Length value (atoi style, saturated to 32 bits, last byte of the
// line dropped), whether a keep-alive key line was seen, and the offset where
// the body starts. After a summary, bytes are dropped until the next
// first_byte. Throughput is one byte per clock unless a summary byte waits on
// out_stall: each byte passes an input register and the compare and
// multiply-by-ten logic that updates the parse state register, and a summary
// then goes to the result register; the state update loop sets the rate. While a
// summary waits on out_stall, bytes that finish no summary keep flowing; only
// a byte that would finish the next summary waits in the input register, and
// in_stall rises once that register is occupied. No clearing pass is needed
// after reset.
// Depends on hrp_pkg and hrp_parse.
module http_request_header_parser #(
  parameter int OFFSET_BITS = 16  // offset counter width, 8..32
) (
  input  logic               clk,
  input  logic               rst,
  // byte input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  input  logic               last_byte,
  // summary output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [1:0]         method_code,
  output logic [15:0]        url_offset,
  output logic [15:0]        url_length,
  output logic               version_ok,
  output logic signed [31:0] body_length,
  output logic               length_seen,
  output logic               persistent,
  output logic [15:0]        body_offset
);

  // input register
  hrp_pkg::item_t   in_q;
  logic             in_q_valid;
  logic             accept;
  logic             advance;

  // parser result and output register
  logic             res_valid;
  hrp_pkg::result_t res;
  hrp_pkg::result_t out_q;

  // a byte moves into the parser unless it finishes a summary while the
  // result slot is held by a stalled one
  assign advance  = in_q_valid && (!res_valid || !out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q.data_byte  <= data_byte;
      in_q.first_byte <= first_byte;
      in_q.last_byte  <= last_byte;
    end
  end

  hrp_parse #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .item     (in_q),
    .res_valid(res_valid),
    .res      (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign status      = out_q.status;
  assign method_code = out_q.method_code;
  assign url_offset  = out_q.url_offset;
  assign url_length  = out_q.url_length;
  assign version_ok  = out_q.version_ok;
  assign body_length = out_q.body_length;
  assign length_seen = out_q.length_seen;
  assign persistent  = out_q.persistent;
  assign body_offset = out_q.body_offset;

endmodule

FILE: src/hrp_checker.sv
// Port-level checks for the HTTP request header parser, bound to the top level.
// Depends on hrp_pkg (status and method codes).
module hrp_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status,
  input logic [1:0]         method_code,
  input logic [15:0]        url_offset,
  input logic [15:0]        url_length,
  input logic               version_ok,
  input logic signed [31:0] body_length,
  input logic               length_seen,
  input logic               persistent,
  input logic [15:0]        body_offset
);

  // a stalled summary stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(body_length) &&
                               $stable(body_offset))
    else $error("summary changed while stalled");

  // an unknown method carries no other findings
  a_bad_method_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == hrp_pkg::ST_BAD_METHOD) |->
      (method_code == hrp_pkg::METHOD_NONE) && (url_offset == 16'd0) &&
      (url_length == 16'd0) && !version_ok && (body_length == 32'sd0) &&
      !length_seen && !persistent && (body_offset == 16'd0))
    else $error("unknown-method summary has nonzero fields");

  // a complete header implies a known method past the request line
  a_done_method: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == hrp_pkg::ST_DONE) |->
      ((method_code == hrp_pkg::METHOD_GET) || (method_code == hrp_pkg::METHOD_POST)) &&
      (body_offset != 16'd0))
    else $error("complete header without method or body offset");

  // no Content-Length line means no body length
  a_no_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && !length_seen |-> (body_length == 32'sd0))
    else $error("body length without a Content-Length line");

  // body offset only on a complete header
  a_offset_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != hrp_pkg::ST_DONE) |-> (body_offset == 16'd0))
    else $error("body offset on an incomplete header");

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .method_code(method_code),
  .url_offset (url_offset),
  .url_length (url_length),
  .version_ok (version_ok),
  .body_length(body_length),
  .length_seen(length_seen),
  .persistent (persistent),
  .body_offset(body_offset)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for http_request_header_parser. Request bytes are queued, driven with
// random gaps and output stalls, and every summary is checked against an in-bench parser.
// Depends on hrp_pkg (codes, characters, item and result types) and the parser RTL.
module testbench;

  localparam int TAIL_ITEMS   = 300;    // no gaps or stalls once this few bytes are left
  localparam int QUIET_LIMIT  = 1000;   // cycles without any transfer before giving up
  localparam int RANDOM_BYTES = 1250;

  // tokens as right-aligned byte strings, first character in the highest byte
  localparam logic [111:0] GET_TOK     = "GET";
  localparam logic [111:0] POST_TOK    = "POST";
  localparam logic [111:0] VERSION_TOK = {"HTTP/1.1", hrp_pkg::CH_CR};
  localparam logic [111:0] LENGTH_TOK  = "Content-Length";
  localparam logic [111:0] ALIVE_TOK   = "keep-alive";

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = 8'h00;
  logic               first_byte = 1'b0;
  logic               last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [1:0]         method_code;
  logic [15:0]        url_offset;
  logic [15:0]        url_length;
  logic               version_ok;
  logic signed [31:0] body_length;
  logic               length_seen;
  logic               persistent;
  logic [15:0]        body_offset;

  http_request_header_parser i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .method_code (method_code),
    .url_offset  (url_offset),
    .url_length  (url_length),
    .version_ok  (version_ok),
    .body_length (body_length),
    .length_seen (length_seen),
    .persistent  (persistent),
    .body_offset (body_offset)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // single reset pulse, released on a falling edge like every other input
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser prediction. Own copy of the parse state; one call per accepted byte.
  // ---------------------------------------------------------------------------
  hrp_pkg::phase_t ph;
  hrp_pkg::dig_t   dig;
  logic [15:0] offs;           // offset of the current byte in the request
  logic [15:0] url_beg;
  logic [15:0] url_cnt;
  logic [3:0]  mpos;           // token match position, sticks at 15
  logic [3:0]  cands;          // bit 0: GET / Content-Length, bit 1: POST / keep-alive
  logic [1:0]  meth;
  logic        ver_ok;
  logic        at_line_start;
  logic        val_mode;       // past the key delimiter of a header line
  logic [31:0] acc;            // value magnitude, saturates at 2^31
  logic        neg;
  logic [8:0]  held;           // one-byte delay so the line's last byte is dropped
  logic        cl_found;
  logic        ka_found;
  logic        finished;       // summary given, ignore bytes until first_byte

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [3:0] pos_inc(input logic [3:0] p);
    return (p == hrp_pkg::POS_MAX) ? p : p + 4'd1;
  endfunction

  function automatic logic tok_byte(input logic [111:0] tok, input int len,
                                    input logic [3:0] p, input logic [7:0] b);
    int pi;
    pi = p;
    if (pi >= len) return 1'b0;
    return tok[8 * (len - 1 - pi) +: 8] == b;
  endfunction

  function automatic void clear_request();
    ph = hrp_pkg::PH_METHOD;
    dig = hrp_pkg::DIG_SKIP;
    offs = 16'd0;
    url_beg = 16'd0;
    url_cnt = 16'd0;
    mpos = 4'd0;
    cands = 4'hF;
    meth = hrp_pkg::METHOD_NONE;
    ver_ok = 1'b1;
    at_line_start = 1'b0;
    val_mode = 1'b0;
    acc = 32'd0;
    neg = 1'b0;
    held = 9'd0;
    cl_found = 1'b0;
    ka_found = 1'b0;
    finished = 1'b0;
  endfunction

  function automatic void restart_key();
    mpos = 4'd0;
    cands = 4'hF;
    at_line_start = 1'b1;
    val_mode = 1'b0;
    held = 9'd0;
  endfunction

  // atoi-style digit parser on the delayed value bytes
  function automatic void feed_digit(input logic [7:0] c);
    logic [35:0] t;
    if (dig == hrp_pkg::DIG_SKIP) begin
      if (c == hrp_pkg::CH_SP || c == hrp_pkg::CH_TAB || c == hrp_pkg::CH_VT ||
          c == hrp_pkg::CH_FF || c == hrp_pkg::CH_CR) return;
      if (c == hrp_pkg::CH_PLUS || c == hrp_pkg::CH_MINUS) begin
        neg = (c == hrp_pkg::CH_MINUS);
        dig = hrp_pkg::DIG_READ;
        return;
      end
      dig = hrp_pkg::DIG_READ;
    end
    if (dig == hrp_pkg::DIG_READ) begin
      if (c >= hrp_pkg::CH_ZERO && c <= hrp_pkg::CH_NINE) begin
        t = acc * 36'd10 + 36'(c - hrp_pkg::CH_ZERO);
        acc = (t > {4'd0, hrp_pkg::MAG_LIMIT}) ? hrp_pkg::MAG_LIMIT : t[31:0];
      end else begin
        dig = hrp_pkg::DIG_STOP;
      end
    end
  endfunction

  function automatic hrp_pkg::result_t summarize(input logic [1:0] st);
    hrp_pkg::result_t r;
    r = '0;
    r.status = st;
    if (st != hrp_pkg::ST_BAD_METHOD) begin
      r.method_code = meth;
      r.url_offset  = url_beg;
      r.url_length  = url_cnt;
      r.version_ok  = (ph == hrp_pkg::PH_HEADER || ph == hrp_pkg::PH_BLANK) ? ver_ok : 1'b0;
      if (cl_found) begin
        r.body_length = neg ? 32'd0 - acc :
                        ((acc > hrp_pkg::POS_LIMIT) ? hrp_pkg::POS_LIMIT : acc);
      end
      r.length_seen = cl_found;
      r.persistent  = ka_found;
      r.body_offset = (st == hrp_pkg::ST_DONE) ? sat_inc(offs) : 16'd0;
    end
    finished = 1'b1;
    return r;
  endfunction

  // returns 1 when this byte completes a summary, which is placed in r
  function automatic logic parse_byte(input logic [7:0] b, input logic fb, input logic lb,
                                      output hrp_pkg::result_t r);
    logic [3:0] p;
    logic       ok;
    r = '0;
    if (fb) clear_request();
    if (finished) return 1'b0;
    p = mpos;
    case (ph)
      hrp_pkg::PH_METHOD: begin
        if (b == hrp_pkg::CH_SP) begin
          if (cands[0] && p == hrp_pkg::GET_LEN) meth = hrp_pkg::METHOD_GET;
          else if (cands[1] && p == hrp_pkg::POST_LEN) meth = hrp_pkg::METHOD_POST;
          if (meth == hrp_pkg::METHOD_NONE) begin
            r = summarize(hrp_pkg::ST_BAD_METHOD);
            return 1'b1;
          end
          ph = hrp_pkg::PH_URL;
          url_beg = sat_inc(offs);
          url_cnt = 16'd0;
        end else begin
          cands = {2'b00, cands[1] && tok_byte(POST_TOK, 4, p, b),
                   cands[0] && tok_byte(GET_TOK, 3, p, b)};
          mpos = pos_inc(p);
        end
      end
      hrp_pkg::PH_URL: begin
        if (b == hrp_pkg::CH_SP) begin
          ph = hrp_pkg::PH_VERSION;
          mpos = 4'd0;
          ver_ok = 1'b1;
        end else begin
          url_cnt = sat_inc(url_cnt);
        end
      end
      hrp_pkg::PH_VERSION: begin
        if (b == hrp_pkg::CH_LF) begin
          ver_ok = ver_ok && (p == hrp_pkg::VERSION_LEN);
          ph = hrp_pkg::PH_HEADER;
          restart_key();
        end else begin
          ver_ok = ver_ok && tok_byte(VERSION_TOK, 9, p, b);
          mpos = pos_inc(p);
        end
      end
      hrp_pkg::PH_HEADER: begin
        if (val_mode) begin
          if (b == hrp_pkg::CH_LF) begin
            restart_key();
          end else begin
            if (held[8] && dig != hrp_pkg::DIG_STOP) feed_digit(held[7:0]);
            held = {1'b1, b};
          end
        end else if (at_line_start && b == hrp_pkg::CH_CR) begin
          ph = hrp_pkg::PH_BLANK;
        end else if (b == hrp_pkg::CH_LF) begin
          restart_key();
        end else if (b == hrp_pkg::CH_COLON || b == hrp_pkg::CH_SP) begin
          if (cands[1] && p == hrp_pkg::ALIVE_LEN) ka_found = 1'b1;
          dig = hrp_pkg::DIG_STOP;
          // only the first Content-Length line is parsed
          if (cands[0] && p == hrp_pkg::LENGTH_LEN && !cl_found) begin
            cl_found = 1'b1;
            dig = hrp_pkg::DIG_SKIP;
            acc = 32'd0;
            neg = 1'b0;
          end
          val_mode = 1'b1;
          held = 9'd0;
          at_line_start = 1'b0;
        end else begin
          cands = {2'b00, cands[1] && tok_byte(ALIVE_TOK, 10, p, b),
                   cands[0] && tok_byte(LENGTH_TOK, 14, p, b)};
          mpos = pos_inc(p);
          at_line_start = 1'b0;
        end
      end
      default: begin
        if (b == hrp_pkg::CH_LF) begin
          r = summarize(hrp_pkg::ST_DONE);
          return 1'b1;
        end
      end
    endcase
    if (lb) begin
      if (ph == hrp_pkg::PH_METHOD) begin
        // a buffer that stops right after GET or POST is cut short, not a bad method
        ok = (cands[0] && mpos == hrp_pkg::GET_LEN) || (cands[1] && mpos == hrp_pkg::POST_LEN);
        r = summarize(ok ? hrp_pkg::ST_TRUNCATED : hrp_pkg::ST_BAD_METHOD);
      end else begin
        r = summarize(hrp_pkg::ST_TRUNCATED);
      end
      return 1'b1;
    end
    offs = sat_inc(offs);
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building: a request is assembled in req, then queued as transfers.
  // ---------------------------------------------------------------------------
  logic [7:0]     req[$];
  hrp_pkg::item_t tx_bytes[$];
  int             random_bytes = 0;
  int             requests_built = 0;

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) req.push_back(s[i]);
  endtask

  task automatic add_line(input string s);
    add_text(s);
    req.push_back(hrp_pkg::CH_CR);
    req.push_back(hrp_pkg::CH_LF);
  endtask

  task automatic add_junk(input int n, input logic [7:0] avoid_a, input logic [7:0] avoid_b);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == avoid_a || c == avoid_b) c = "x";
      req.push_back(c);
    end
  endtask

  task automatic add_eol();
    if ($urandom_range(0, 6) != 0) req.push_back(hrp_pkg::CH_CR);
    req.push_back(hrp_pkg::CH_LF);
  endtask

  task automatic add_length_value();
    logic [7:0] d;
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0: req.push_back(hrp_pkg::CH_SP);
        1: req.push_back(hrp_pkg::CH_TAB);
        2: req.push_back(hrp_pkg::CH_VT);
        3: req.push_back(hrp_pkg::CH_FF);
        default: req.push_back(hrp_pkg::CH_CR);
      endcase
    end
    case ($urandom_range(0, 9))
      0: add_text("+");
      1, 2: add_text("-");
      3: add_text("+-");
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: add_text($sformatf("%0d", $urandom_range(0, 999)));
      1, 2: add_text($sformatf("%0d", $urandom()));
      3: begin
        repeat ($urandom_range(10, 14)) begin
          d = hrp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
          req.push_back(d);
        end
      end
      4: begin
        case ($urandom_range(0, 3))
          0: add_text("2147483647");
          1: add_text("2147483648");
          2: add_text("2147483649");
          default: add_text("4294967296");
        endcase
      end
      5: ;
      default: add_text($sformatf("%0d", $urandom_range(0, 99999)));
    endcase
    if ($urandom_range(0, 4) == 0) add_junk($urandom_range(1, 3), hrp_pkg::CH_LF, hrp_pkg::CH_LF);
  endtask

  task automatic add_delim();
    req.push_back(($urandom_range(0, 4) == 0) ? hrp_pkg::CH_SP : hrp_pkg::CH_COLON);
  endtask

  task automatic add_header_line();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        add_text("Content-Length");
        add_delim();
        add_length_value();
      end
      3, 4: begin
        add_text("keep-alive");
        add_delim();
        add_junk($urandom_range(0, 5), hrp_pkg::CH_LF, hrp_pkg::CH_LF);
      end
      5: begin
        // keys close to the real ones but not equal to them
        case ($urandom_range(0, 5))
          0: add_text("Content-Lengt");
          1: add_text("Content-Lengthh");
          2: add_text("content-length");
          3: add_text("keep-aliv");
          4: add_text("Keep-Alive");
          default: add_text("keep-alivee");
        endcase
        add_text(": 5");
      end
      6, 7: begin
        add_text("Host: ");
        add_junk($urandom_range(0, 12), hrp_pkg::CH_LF, hrp_pkg::CH_LF);
      end
      8: begin
        // no delimiter at all: the line is dropped
        if ($urandom_range(0, 1) == 0) begin
          add_text("Content-Length");
        end else begin
          repeat ($urandom_range(1, 8)) begin
            c = 8'("a") + 8'($urandom_range(0, 25));
            req.push_back(c);
          end
        end
      end
      9: begin
        req.push_back(hrp_pkg::CH_LF);  // bare LF line, ignored
        return;
      end
      10: begin
        add_junk($urandom_range(1, 6), hrp_pkg::CH_LF, hrp_pkg::CH_COLON);
        req.push_back(hrp_pkg::CH_COLON);
        add_junk($urandom_range(0, 6), hrp_pkg::CH_LF, hrp_pkg::CH_LF);
      end
      default: add_junk($urandom_range(0, 10), hrp_pkg::CH_LF, hrp_pkg::CH_LF);
    endcase
    add_eol();
  endtask

  task automatic build_request();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 9) add_text("GET");
    else if (sel < 16) add_text("POST");
    else if (sel == 16) begin
      case ($urandom_range(0, 4))
        0: add_text("PUT");
        1: add_text("GE");
        2: add_text("POSTT");
        3: add_text("GETGET");
        default: add_text("get");
      endcase
    end else if (sel == 17) add_junk($urandom_range(1, 5), hrp_pkg::CH_SP, hrp_pkg::CH_SP);
    else if (sel == 19) add_text("POS");
    add_text(" ");
    if ($urandom_range(0, 4) != 0) add_text("/");
    if ($urandom_range(0, 4) == 0) begin
      add_junk($urandom_range(0, 20), hrp_pkg::CH_SP, hrp_pkg::CH_SP);
    end else begin
      repeat ($urandom_range(0, 20)) req.push_back(8'($urandom_range(33, 126)));
    end
    add_text(" ");
    sel = $urandom_range(0, 11);
    if (sel < 8) add_line("HTTP/1.1");
    else if (sel == 8) add_line("HTTP/1.0");
    else if (sel == 9) begin
      add_text("HTTP/1.1");
      req.push_back(hrp_pkg::CH_LF);
    end else if (sel == 10) add_line("HTTP/1.11");
    else begin
      add_junk($urandom_range(0, 10), hrp_pkg::CH_LF, hrp_pkg::CH_LF);
      req.push_back(hrp_pkg::CH_LF);
    end
    repeat ($urandom_range(0, 4)) add_header_line();
    if ($urandom_range(0, 6) != 0) begin
      add_line("");
    end else begin
      // bytes between the blank line's CR and LF are skipped
      req.push_back(hrp_pkg::CH_CR);
      add_junk($urandom_range(0, 3), hrp_pkg::CH_LF, hrp_pkg::CH_LF);
      req.push_back(hrp_pkg::CH_LF);
    end
  endtask

  // queue req; stop_at >= 0 cuts the buffer after that byte, ends marks the final byte
  task automatic push_request(input int stop_at, input bit ends);
    int             n;
    hrp_pkg::item_t it;
    n = req.size();
    if (stop_at >= 0 && stop_at < n) n = stop_at + 1;
    for (int i = 0; i < n; i++) begin
      it.data_byte  = req[i];
      it.first_byte = (i == 0);
      it.last_byte  = (i == n - 1) && (ends || stop_at >= 0);
      tx_bytes.push_back(it);
    end
    req.delete();
  endtask

  // raw bytes with random framing flags
  task automatic push_noise(input int n, input int first_odds, input int last_odds);
    hrp_pkg::item_t it;
    repeat (n) begin
      it.data_byte  = 8'($urandom_range(0, 255));
      it.first_byte = ($urandom_range(0, first_odds) == 0);
      it.last_byte  = ($urandom_range(0, last_odds) == 0);
      tx_bytes.push_back(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one queued byte per transfer, with random idle gaps between bytes.
  // ---------------------------------------------------------------------------
  logic           in_took = 1'b0;   // a byte transfer happened at the last rising edge
  logic           calm = 1'b0;      // stretches with no gaps and no stalls
  int             in_gap = 0;
  int             out_gap = 0;
  hrp_pkg::item_t next_item;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (tx_bytes.size() > TAIL_ITEMS && !calm && $urandom_range(0, 7) == 0) begin
        in_gap <= int'($urandom_range(0, 12));
        in_valid <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        next_item = tx_bytes.pop_front();
        in_valid <= 1'b1;
        data_byte <= next_item.data_byte;
        first_byte <= next_item.first_byte;
        last_byte <= next_item.last_byte;
        if ($urandom_range(0, 149) == 0) calm <= !calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall in bursts, independent of out_valid
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (tx_bytes.size() > TAIL_ITEMS && !calm && $urandom_range(0, 4) == 0) begin
      out_gap <= int'($urandom_range(0, 12));
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard, all at the rising edge.
  // ---------------------------------------------------------------------------
  hrp_pkg::result_t expected_summaries[$];
  hrp_pkg::result_t predicted;
  int      bytes_in = 0;
  int      mismatches = 0;
  int      done_count = 0;
  int      bad_count = 0;
  int      cut_count = 0;
  int      quiet_cycles = 0;

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
               $time, name, want, want, got, got);
      mismatches++;
    end
  endtask

  task automatic check_summary();
    hrp_pkg::result_t want;
    if (expected_summaries.size() == 0) begin
      $display("%0t: summary with status %0d arrived, none expected", $time, status);
      mismatches++;
    end else begin
      want = expected_summaries.pop_front();
      compare_field("status", 32'(want.status), 32'(status));
      compare_field("method_code", 32'(want.method_code), 32'(method_code));
      compare_field("url_offset", 32'(want.url_offset), 32'(url_offset));
      compare_field("url_length", 32'(want.url_length), 32'(url_length));
      compare_field("version_ok", 32'(want.version_ok), 32'(version_ok));
      compare_field("body_length", want.body_length, body_length);
      compare_field("length_seen", 32'(want.length_seen), 32'(length_seen));
      compare_field("persistent", 32'(want.persistent), 32'(persistent));
      compare_field("body_offset", 32'(want.body_offset), 32'(body_offset));
      if (want.status == hrp_pkg::ST_DONE) done_count++;
      else if (want.status == hrp_pkg::ST_BAD_METHOD) bad_count++;
      else cut_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) check_summary();
      if (in_valid && !in_stall) begin
        bytes_in++;
        if (parse_byte(data_byte, first_byte, last_byte, predicted))
          expected_summaries.push_back(predicted);
      end
    end
  end

  // watchdog on cycles without any transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d summaries outstanding",
               $time, QUIET_LIMIT, expected_summaries.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    int cut;
    clear_request();

    // complete GET with length and keep-alive, then bytes that must be ignored
    add_text("GET /index.html ");
    add_line("HTTP/1.1");
    add_line("Host: a.b");
    add_line("Content-Length: 42");
    add_line("keep-alive: 1");
    add_line("");
    push_request(-1, 1'b0);
    push_noise(3, 1000, 3);
    // POST: skipped whitespace, negative saturation, second length ignored,
    // space as key delimiter, blank-line LF is also the last byte
    add_text("POST /x ");
    add_line("HTTP/1.1");
    add_text("Content-Length:");
    req.push_back(hrp_pkg::CH_SP);
    req.push_back(hrp_pkg::CH_TAB);
    req.push_back(hrp_pkg::CH_VT);
    req.push_back(hrp_pkg::CH_FF);
    req.push_back(hrp_pkg::CH_CR);
    add_line("-2147483649");
    add_line("Content-Length: 5");
    add_line("keep-alive yes");
    add_line("");
    push_request(-1, 1'b1);
    // lines without delimiter and a bare LF line are dropped; positive saturation
    add_text("POST / ");
    add_line("HTTP/1.0");
    add_line("Content-Length");
    req.push_back(hrp_pkg::CH_LF);
    add_line("nodelimiter");
    add_line("Content-Length: +99999999999x7");
    add_line("");
    push_request(-1, 1'b0);
    // version without CR, empty value
    add_text("GET /a HTTP/1.1");
    req.push_back(hrp_pkg::CH_LF);
    add_text("Content-Length:");
    req.push_back(hrp_pkg::CH_LF);
    add_line("");
    push_request(-1, 1'b0);
    // unknown methods, including an empty token
    add_text("PUT / HTTP/1.1");
    push_request(-1, 1'b0);
    add_text(" ");
    push_request(-1, 1'b1);
    // buffer ending inside the method token
    add_text("G");
    push_request(-1, 1'b1);
    add_text("GE");
    push_request(-1, 1'b1);
    add_text("GET");
    push_request(-1, 1'b1);
    add_text("POST");
    push_request(-1, 1'b1);
    // buffer ending in URL, version, header value and blank line
    add_text("GET /ab");
    push_request(-1, 1'b1);
    add_text("POST /q HTTP/1.");
    push_request(-1, 1'b1);
    add_text("GET / ");
    add_line("HTTP/1.1");
    add_text("Content-Length: 12");
    push_request(-1, 1'b1);
    add_text("GET / ");
    add_line("HTTP/1.1");
    req.push_back(hrp_pkg::CH_CR);
    push_request(-1, 1'b1);
    // zero and all-ones bytes as ordinary data
    add_text("GET /");
    req.push_back(8'h00);
    req.push_back(8'hFF);
    add_text(" ");
    add_line("HTTP/1.1");
    add_text("x:");
    req.push_back(8'h00);
    req.push_back(8'hFF);
    add_line("");
    add_line("");
    push_request(-1, 1'b0);

    // random requests, mostly well formed, some cut short, some noise in between
    while (random_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 11) == 0) begin
        push_noise($urandom_range(1, 30), 3, 5);
      end else begin
        build_request();
        random_bytes += req.size();
        requests_built++;
        cut = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, req.size() - 1)) : -1;
        push_request(cut, $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 9) == 0) push_noise($urandom_range(1, 4), 1000, 3);
      end
    end

    while (tx_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d request bytes, %0d random requests plus directed cases",
             bytes_in, requests_built);
    $display("Summaries: %0d complete, %0d bad method, %0d cut short; %0d mismatches",
             done_count, bad_count, cut_count, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
